// ===== rtl/core/irpdt_pkg.sv =====
`default_nettype none

package irpdt_pkg;

  // Width of every timing register and timing counter
  localparam int unsigned TimeW = 17;

  // Item operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_GAP     = 2'd0;
  localparam logic [1:0] REG_SHORT   = 2'd1;
  localparam logic [1:0] REG_LONG    = 2'd2;
  localparam logic [1:0] REG_CARRIER = 2'd3;

  localparam logic [TimeW-1:0] GAP_RST     = 17'd49766;
  localparam logic [TimeW-1:0] SHORT_RST   = 17'd6248;
  localparam logic [TimeW-1:0] LONG_RST    = 17'd18635;
  localparam logic [TimeW-1:0] CARRIER_RST = 17'd144;

  // Header mark lasts two gaps, trailer space six gaps
  localparam logic [2:0] HEAD_GAPS = 3'd2;
  localparam logic [2:0] TAIL_GAPS = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD_SPACE,
    PH_HEAD_MARK,
    PH_HEAD_SPACE,
    PH_BIT_MARK,
    PH_BIT_SPACE,
    PH_TAIL_MARK,
    PH_TAIL_SPACE
  } phase_t;

  typedef struct packed {
    logic carrier_pin;
    logic envelope;
    logic busy_res;
    logic done_res;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/irpdt_if.sv =====
`default_nettype none

interface irpdt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       bit_value;
  logic [7:0] frame_length;

  modport source (output valid, op, bit_value, frame_length, input ready);
  modport sink (input valid, op, bit_value, frame_length, output ready);
endinterface

interface irpdt_out_if;
  logic valid;
  logic ready;
  logic carrier_pin;
  logic envelope;
  logic busy_res;
  logic done_res;

  modport source (output valid, carrier_pin, envelope, busy_res, done_res, input ready);
  modport sink (input valid, carrier_pin, envelope, busy_res, done_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ir_pulse_distance_transmitter.sv =====
// Pulse-distance infrared transmitter with a gated carrier.
// Input channel in_ch: each transfer carries op, bit_value and frame_length.
//   op write appends bit_value to the bit buffer, op start sends the
//   buffered frame (frame_length bits, saturated to MAX_BITS), op tick
//   advances the frame sequencer and the carrier timer by one timer clock.
// Result channel out_ch: exactly one result per input transfer, in order,
//   carrying the pins after the item, busy_res and done_res.
// Each result is registered into the output queue on its input transfer.
// Throughput: one item per cycle while ready. The bit buffer is a synchronous
//   memory written at one port while idle and read every cycle at the next
//   bit index, so the bit needed by a bit space is always in its read register.
// Stall: results go into a two-entry output queue; in_ch.ready drops only
//   while both entries hold results the receiver has not taken.
// Reset (rst_n low, synchronous): sequencer idle, pointers cleared, pins
//   low/space, registers back to their defaults. The bit buffer is not
//   cleared; a frame must only send bits that were written.
// Configuration: APB writes at byte address 4*index, taken at any time; the
//   timing registers are compared live, so a write during a frame acts at once.
`default_nettype none

module ir_pulse_distance_transmitter #(
  parameter int unsigned MAX_BITS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  irpdt_in_if.sink         in_ch,
  irpdt_out_if.source      out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned TW = irpdt_pkg::TimeW;
  // Counter width holds MAX_BITS itself; address width indexes the buffer
  localparam int unsigned CW = $clog2(MAX_BITS + 1);
  localparam int unsigned AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam logic [8:0]    MaxLen9  = 9'(MAX_BITS);
  localparam logic [CW-1:0] MaxLenCw = CW'(MAX_BITS);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [TW-1:0] gap_r, short_r, long_r, chalf_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r   <= irpdt_pkg::GAP_RST;
      short_r <= irpdt_pkg::SHORT_RST;
      long_r  <= irpdt_pkg::LONG_RST;
      chalf_r <= irpdt_pkg::CARRIER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        irpdt_pkg::REG_GAP:     gap_r   <= cfg_pwdata[TW-1:0];
        irpdt_pkg::REG_SHORT:   short_r <= cfg_pwdata[TW-1:0];
        irpdt_pkg::REG_LONG:    long_r  <= cfg_pwdata[TW-1:0];
        irpdt_pkg::REG_CARRIER: chalf_r <= cfg_pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      irpdt_pkg::REG_GAP:     cfg_prdata = {(32 - TW)'(0), gap_r};
      irpdt_pkg::REG_SHORT:   cfg_prdata = {(32 - TW)'(0), short_r};
      irpdt_pkg::REG_LONG:    cfg_prdata = {(32 - TW)'(0), long_r};
      irpdt_pkg::REG_CARRIER: cfg_prdata = {(32 - TW)'(0), chalf_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Item decode
  // ---------------------------------------------------------------------
  logic [1:0] cnt_r, cnt_nxt;
  logic       in_fire, out_fire;
  logic       busy;
  logic       is_tick, is_write, is_start;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign in_fire     = in_ch.valid && in_ch.ready;

  irpdt_pkg::phase_t phase_r, phase_nxt;

  assign busy     = (phase_r != irpdt_pkg::PH_IDLE);
  assign is_tick  = in_fire && (in_ch.op == irpdt_pkg::OP_TICK) && busy;
  assign is_write = in_fire && (in_ch.op == irpdt_pkg::OP_WRITE) && !busy;
  assign is_start = in_fire && (in_ch.op == irpdt_pkg::OP_START) && !busy;

  // ---------------------------------------------------------------------
  // Bit buffer: written only while idle, read every cycle at the index the
  // sequencer holds next. Writes and sequencer reads never overlap, since
  // the index only moves while a frame is in flight or on a start.
  // ---------------------------------------------------------------------
  logic          mem [MAX_BITS];
  logic          rd_bit_r;
  logic [CW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] bidx_r, bidx_nxt;
  logic          mem_wr;

  assign mem_wr = is_write && (wp_r < MaxLenCw);
  assign wp_nxt = is_start ? '0 : (mem_wr ? wp_r + 1'b1 : wp_r);

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wp_r[AW-1:0]] <= in_ch.bit_value;
    end
    rd_bit_r <= mem[bidx_nxt[AW-1:0]];
  end

  // ---------------------------------------------------------------------
  // Frame sequencer: next state
  // ---------------------------------------------------------------------
  logic [CW-1:0] slen_r, slen_nxt;
  logic [2:0]    gap_rep_r, gap_rep_nxt, gap_inc;
  logic [TW-1:0] seg_r, seg_nxt, seg_inc, seg_len;
  logic          line_r, line_nxt;
  logic          seg_end, done;
  logic [8:0]    flen9;
  logic [CW-1:0] bidx_inc;

  assign flen9    = {1'b0, in_ch.frame_length};
  assign slen_nxt = is_start ? ((flen9 > MaxLen9) ? MaxLenCw : CW'(flen9)) : slen_r;
  assign seg_inc  = seg_r + 1'b1;
  assign gap_inc  = gap_rep_r + 1'b1;
  assign bidx_inc = bidx_r + 1'b1;

  always_comb begin
    unique case (phase_r)
      irpdt_pkg::PH_LEAD_SPACE,
      irpdt_pkg::PH_HEAD_MARK,
      irpdt_pkg::PH_HEAD_SPACE,
      irpdt_pkg::PH_TAIL_SPACE: seg_len = gap_r;
      irpdt_pkg::PH_BIT_SPACE:  seg_len = rd_bit_r ? long_r : short_r;
      default:                  seg_len = short_r;
    endcase
  end

  assign seg_end = is_tick && (seg_inc >= seg_len);

  always_comb begin
    phase_nxt   = phase_r;
    seg_nxt     = seg_r;
    gap_rep_nxt = gap_rep_r;
    bidx_nxt    = bidx_r;
    line_nxt    = line_r;
    done        = 1'b0;
    if (is_start) begin
      phase_nxt   = irpdt_pkg::PH_LEAD_SPACE;
      seg_nxt     = '0;
      gap_rep_nxt = '0;
      bidx_nxt    = '0;
      line_nxt    = 1'b1;
    end else if (is_tick && !seg_end) begin
      seg_nxt = seg_inc;
    end else if (seg_end) begin
      seg_nxt = '0;
      unique case (phase_r)
        irpdt_pkg::PH_LEAD_SPACE: begin
          gap_rep_nxt = '0;
          phase_nxt   = irpdt_pkg::PH_HEAD_MARK;
          line_nxt    = 1'b0;
        end
        irpdt_pkg::PH_HEAD_MARK: begin
          gap_rep_nxt = gap_inc;
          if (gap_inc >= irpdt_pkg::HEAD_GAPS) begin
            gap_rep_nxt = '0;
            phase_nxt   = irpdt_pkg::PH_HEAD_SPACE;
            line_nxt    = 1'b1;
          end
        end
        irpdt_pkg::PH_HEAD_SPACE: begin
          bidx_nxt  = '0;
          phase_nxt = (slen_r == '0) ? irpdt_pkg::PH_TAIL_MARK : irpdt_pkg::PH_BIT_MARK;
          line_nxt  = 1'b0;
        end
        irpdt_pkg::PH_BIT_MARK: begin
          phase_nxt = irpdt_pkg::PH_BIT_SPACE;
          line_nxt  = 1'b1;
        end
        irpdt_pkg::PH_BIT_SPACE: begin
          bidx_nxt  = bidx_inc;
          phase_nxt = (bidx_inc >= slen_r) ? irpdt_pkg::PH_TAIL_MARK
                                           : irpdt_pkg::PH_BIT_MARK;
          line_nxt  = 1'b0;
        end
        irpdt_pkg::PH_TAIL_MARK: begin
          gap_rep_nxt = '0;
          phase_nxt   = irpdt_pkg::PH_TAIL_SPACE;
          line_nxt    = 1'b1;
        end
        irpdt_pkg::PH_TAIL_SPACE: begin
          gap_rep_nxt = gap_inc;
          if (gap_inc >= irpdt_pkg::TAIL_GAPS) begin
            gap_rep_nxt = '0;
            phase_nxt   = irpdt_pkg::PH_IDLE;
            done        = 1'b1;
          end
        end
        default: phase_nxt = irpdt_pkg::PH_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Carrier generator: outputs. Sample the line level held before this
  // tick's segment change.
  // ---------------------------------------------------------------------
  logic [TW-1:0] cc_r, cc_nxt, cc_inc;
  logic          cphase_r, cphase_nxt;
  logic          pin_r, pin_nxt;
  logic          env_r, env_nxt;
  logic          fire;

  assign cc_inc = cc_r + 1'b1;
  assign fire   = is_tick && (cc_inc >= chalf_r);

  always_comb begin
    cc_nxt     = cc_r;
    cphase_nxt = cphase_r;
    pin_nxt    = pin_r;
    env_nxt    = env_r;
    if (is_start) begin
      cc_nxt = '0;
    end else if (fire) begin
      cc_nxt  = '0;
      env_nxt = line_r;
      if (line_r) begin
        pin_nxt = 1'b0;
      end else begin
        pin_nxt    = cphase_r;
        cphase_nxt = !cphase_r;
      end
    end else if (is_tick) begin
      cc_nxt = cc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= irpdt_pkg::PH_IDLE;
      seg_r     <= '0;
      gap_rep_r <= '0;
      bidx_r    <= '0;
      slen_r    <= '0;
      wp_r      <= '0;
      line_r    <= 1'b1;
      cc_r      <= '0;
      cphase_r  <= 1'b0;
      pin_r     <= 1'b0;
      env_r     <= 1'b1;
    end else begin
      phase_r   <= phase_nxt;
      seg_r     <= seg_nxt;
      gap_rep_r <= gap_rep_nxt;
      bidx_r    <= bidx_nxt;
      slen_r    <= slen_nxt;
      wp_r      <= wp_nxt;
      line_r    <= line_nxt;
      cc_r      <= cc_nxt;
      cphase_r  <= cphase_nxt;
      pin_r     <= pin_nxt;
      env_r     <= env_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Two-entry output queue; head in q0_r
  // ---------------------------------------------------------------------
  irpdt_pkg::res_t res_new, q0_r, q0_nxt, q1_r, q1_nxt;

  assign res_new = '{carrier_pin: pin_nxt, envelope: env_nxt,
                     busy_res: (phase_nxt != irpdt_pkg::PH_IDLE), done_res: done};
  assign out_fire = out_ch.valid && out_ch.ready;

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (in_fire && !out_fire) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 2'd0) begin
        q0_nxt = res_new;
      end else begin
        q1_nxt = res_new;
      end
    end else if (!in_fire && out_fire) begin
      cnt_nxt = cnt_r - 1'b1;
      q0_nxt  = q1_r;
    end else if (in_fire && out_fire) begin
      if (cnt_r == 2'd1) begin
        q0_nxt = res_new;
      end else begin
        q0_nxt = q1_r;
        q1_nxt = res_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.carrier_pin = q0_r.carrier_pin;
  assign out_ch.envelope    = q0_r.envelope;
  assign out_ch.busy_res    = q0_r.busy_res;
  assign out_ch.done_res    = q0_r.done_res;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_idle_until_start: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == irpdt_pkg::PH_IDLE && !(in_fire && in_ch.op == irpdt_pkg::OP_START))
      |=> phase_r == irpdt_pkg::PH_IDLE)
    else $error("sequencer left idle without a start");

  a_bit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == irpdt_pkg::PH_BIT_MARK || phase_r == irpdt_pkg::PH_BIT_SPACE)
      |-> bidx_r < slen_r)
    else $error("bit index beyond frame length");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= MaxLenCw)
    else $error("write pointer beyond buffer");

endmodule

`default_nettype wire

// ===== verif/tb_ir_pulse_distance_transmitter.sv =====
module tb_ir_pulse_distance_transmitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BITS = 128;
  localparam logic [7:0] MAX_LEN = 8'(MAX_BITS);
  // op code 3 has no meaning: the block answers it but changes nothing
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned HOLD_CYCLES = 48;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic [16:0] TIME_MAX = 17'h10000;

  logic clk = 1'b0;
  logic rst_n;

  irpdt_in_if in_ch ();
  irpdt_out_if out_ch ();

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ir_pulse_distance_transmitter #(
    .MAX_BITS(MAX_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Transmitter mirror: timing registers, bit buffer, sequencer, carrier
  // ---------------------------------------------------------------------
  logic [16:0]       gap_reg, short_reg, long_reg, carrier_reg;
  logic              buf_bits [MAX_BITS];
  logic [7:0]        wr_ptr_m, tx_len, cur_bit;
  irpdt_pkg::phase_t seq_phase;
  logic [2:0]        gap_count;
  logic [16:0]       seg_ticks, car_ticks;
  logic              car_toggle, line_q, pin_q, env_q;

  // pins and flags still owed by the block, oldest first
  irpdt_pkg::res_t pending_pins[$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_done = 0;
  int unsigned frames_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned bits_written = 0;
  int unsigned settings_used = 0;

  // random idling on each side, and a long result hold-off on request
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int unsigned stall_cycles_req = 0;
  int unsigned quiet_cycles = 0;

  task automatic clear_transmitter_state();
    gap_reg = irpdt_pkg::GAP_RST;
    short_reg = irpdt_pkg::SHORT_RST;
    long_reg = irpdt_pkg::LONG_RST;
    carrier_reg = irpdt_pkg::CARRIER_RST;
    foreach (buf_bits[i]) buf_bits[i] = 1'b0;
    wr_ptr_m = '0;
    tx_len = '0;
    cur_bit = '0;
    seq_phase = irpdt_pkg::PH_IDLE;
    gap_count = '0;
    seg_ticks = '0;
    car_ticks = '0;
    car_toggle = 1'b0;
    line_q = 1'b1;
    pin_q = 1'b0;
    env_q = 1'b1;
  endtask

  // Enter a segment: restart its counter and set the line (marks are 0)
  function automatic void enter_segment(irpdt_pkg::phase_t p);
    seq_phase = p;
    seg_ticks = '0;
    line_q = (p == irpdt_pkg::PH_HEAD_MARK || p == irpdt_pkg::PH_BIT_MARK ||
              p == irpdt_pkg::PH_TAIL_MARK) ? 1'b0 : 1'b1;
  endfunction

  function automatic logic [16:0] segment_span();
    case (seq_phase)
      irpdt_pkg::PH_LEAD_SPACE, irpdt_pkg::PH_HEAD_MARK,
      irpdt_pkg::PH_HEAD_SPACE, irpdt_pkg::PH_TAIL_SPACE: segment_span = gap_reg;
      irpdt_pkg::PH_BIT_SPACE:
        segment_span = (cur_bit < MAX_BITS && buf_bits[cur_bit]) ? long_reg : short_reg;
      default: segment_span = short_reg;
    endcase
  endfunction

  // One timer clock; returns 1 on the tick that ends the frame
  function automatic bit timer_tick();
    if (seq_phase == irpdt_pkg::PH_IDLE) return 1'b0;
    // carrier firing samples the line before any segment change this tick
    car_ticks = car_ticks + 17'd1;
    if (car_ticks >= carrier_reg) begin
      car_ticks = '0;
      env_q = line_q;
      if (line_q) begin
        pin_q = 1'b0;
      end else begin
        pin_q = car_toggle;
        car_toggle = ~car_toggle;
      end
    end
    seg_ticks = seg_ticks + 17'd1;
    if (seg_ticks < segment_span()) return 1'b0;
    seg_ticks = '0;
    case (seq_phase)
      irpdt_pkg::PH_LEAD_SPACE: begin
        gap_count = '0;
        enter_segment(irpdt_pkg::PH_HEAD_MARK);
      end
      irpdt_pkg::PH_HEAD_MARK: begin
        gap_count = gap_count + 3'd1;
        if (gap_count >= irpdt_pkg::HEAD_GAPS) begin
          gap_count = '0;
          enter_segment(irpdt_pkg::PH_HEAD_SPACE);
        end
      end
      irpdt_pkg::PH_HEAD_SPACE: begin
        cur_bit = '0;
        enter_segment(tx_len == 8'd0 ? irpdt_pkg::PH_TAIL_MARK : irpdt_pkg::PH_BIT_MARK);
      end
      irpdt_pkg::PH_BIT_MARK: enter_segment(irpdt_pkg::PH_BIT_SPACE);
      irpdt_pkg::PH_BIT_SPACE: begin
        cur_bit = cur_bit + 8'd1;
        enter_segment(cur_bit >= tx_len ? irpdt_pkg::PH_TAIL_MARK : irpdt_pkg::PH_BIT_MARK);
      end
      irpdt_pkg::PH_TAIL_MARK: begin
        gap_count = '0;
        enter_segment(irpdt_pkg::PH_TAIL_SPACE);
      end
      irpdt_pkg::PH_TAIL_SPACE: begin
        gap_count = gap_count + 3'd1;
        if (gap_count >= irpdt_pkg::TAIL_GAPS) begin
          gap_count = '0;
          seq_phase = irpdt_pkg::PH_IDLE;
          return 1'b1;
        end
      end
      default: seq_phase = irpdt_pkg::PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // Apply one accepted item to the mirror; took is low when the block ignores it
  task automatic ir_frame_step(input logic [1:0] op, input logic bitv, input logic [7:0] flen,
                               output irpdt_pkg::res_t r, output bit took);
    bit was_idle;
    bit done;
    was_idle = (seq_phase == irpdt_pkg::PH_IDLE);
    done = 1'b0;
    took = 1'b0;
    case (op)
      irpdt_pkg::OP_TICK: begin
        took = !was_idle;
        done = timer_tick();
        if (took) ticks_sent++;
      end
      irpdt_pkg::OP_WRITE: begin
        if (was_idle && wr_ptr_m < MAX_BITS) begin
          buf_bits[wr_ptr_m] = bitv;
          wr_ptr_m = wr_ptr_m + 8'd1;
          took = 1'b1;
          bits_written++;
        end
      end
      irpdt_pkg::OP_START: begin
        if (was_idle) begin
          tx_len = (flen > MAX_LEN) ? MAX_LEN : flen;
          wr_ptr_m = '0;
          cur_bit = '0;
          gap_count = '0;
          car_ticks = '0;
          // carrier phase carries over from the previous frame
          enter_segment(irpdt_pkg::PH_LEAD_SPACE);
          took = 1'b1;
          frames_sent++;
        end
      end
      default: ;
    endcase
    r.carrier_pin = pin_q;
    r.envelope = env_q;
    r.busy_res = (seq_phase != irpdt_pkg::PH_IDLE);
    r.done_res = done;
  endtask

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offer one item from a falling edge and hold it until the transfer;
  // return at the next falling edge with valid still high.
  task automatic send_item(input logic [1:0] op, input logic bitv, input logic [7:0] flen);
    irpdt_pkg::res_t r;
    bit              took;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.bit_value = bitv;
    in_ch.frame_length = flen;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ir_frame_step(op, bitv, flen, r, took);
    pending_pins.push_back(r);
    if (took) items_done++;
    @(negedge clk);
  endtask

  // Drop valid and hold until the block owes nothing
  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (pending_pins.size() != 0) @(negedge clk);
  endtask

  // Keep ticking until the frame ends; noisy mixes in writes, starts and
  // op 3 that a busy block must ignore
  task automatic tick_until_idle(input bit noisy);
    while (seq_phase != irpdt_pkg::PH_IDLE) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_item(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
      else
        send_item(irpdt_pkg::OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  task automatic write_timing_reg(input logic [1:0] idx, input logic [16:0] val);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = {15'd0, val};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      irpdt_pkg::REG_GAP: gap_reg = val;
      irpdt_pkg::REG_SHORT: short_reg = val;
      irpdt_pkg::REG_LONG: long_reg = val;
      irpdt_pkg::REG_CARRIER: carrier_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // Drain, let the last result settle, then load all four timings
  task automatic set_timing(input logic [16:0] gap, input logic [16:0] short_val,
                            input logic [16:0] long_val, input logic [16:0] carrier);
    wait_drain();
    repeat (2) @(negedge clk);
    write_timing_reg(irpdt_pkg::REG_GAP, gap);
    write_timing_reg(irpdt_pkg::REG_SHORT, short_val);
    write_timing_reg(irpdt_pkg::REG_LONG, long_val);
    write_timing_reg(irpdt_pkg::REG_CARRIER, carrier);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Drive ready at each falling edge: a requested hold-off first, else a
  // random stall burst while receiver idling is on, else ready high.
  initial begin : result_ready_driver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_cycles_req != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall_cycles_req) @(negedge clk);
        stall_cycles_req = 0;
        out_ch.ready = 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic report_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare every result transfer with the oldest owed result
  always @(posedge clk) begin : result_check
    irpdt_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_pins.size() == 0) begin
        $display("%0t: result with nothing owed, expected none actual pin=%0b env=%0b busy=%0b done=%0b",
                 $time, out_ch.carrier_pin, out_ch.envelope, out_ch.busy_res, out_ch.done_res);
        mismatches++;
      end else begin
        want = pending_pins.pop_front();
        report_field("carrier_pin", want.carrier_pin, out_ch.carrier_pin);
        report_field("envelope", want.envelope, out_ch.envelope);
        report_field("busy_res", want.busy_res, out_ch.busy_res);
        report_field("done_res", want.done_res, out_ch.done_res);
      end
    end
  end

  // Stop a hung run: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results still owed",
               $time, WATCHDOG_LIMIT, pending_pins.size());
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Idle ticks and op 3 right after reset: pins low/space, nothing busy
  task automatic test_idle_after_reset();
    send_item(irpdt_pkg::OP_TICK, 1'b0, 8'h00);
    send_item(irpdt_pkg::OP_TICK, 1'b1, 8'hFF);
    send_item(OP_NONE, 1'b1, 8'hFF);
  endtask

  // Fill the whole buffer (two extra writes bounce off a full buffer) and
  // send it with a length past MAX_BITS so it saturates; all timings at 1.
  // Every entry is written from here on, so any length is safe later.
  task automatic test_full_buffer_frame();
    set_timing(17'd1, 17'd1, 17'd1, 17'd1);
    repeat (MAX_BITS + 2)
      send_item(irpdt_pkg::OP_WRITE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    send_item(irpdt_pkg::OP_START, 1'b0, 8'hFF);
    tick_until_idle(1'b0);
  endtask

  // Mixed bits with distinct short/long spaces; writes, starts and op 3
  // arriving mid-frame must be ignored
  task automatic test_mixed_bit_frame();
    set_timing(17'd2, 17'd1, 17'd3, 17'd2);
    send_item(irpdt_pkg::OP_WRITE, 1'b1, 8'h00);
    send_item(irpdt_pkg::OP_WRITE, 1'b0, 8'h00);
    send_item(irpdt_pkg::OP_WRITE, 1'b1, 8'h00);
    send_item(irpdt_pkg::OP_START, 1'b0, 8'd3);
    send_item(irpdt_pkg::OP_TICK, 1'b0, 8'd0);
    send_item(irpdt_pkg::OP_WRITE, 1'b1, 8'd0);
    send_item(irpdt_pkg::OP_START, 1'b1, 8'd5);
    send_item(OP_NONE, 1'b0, 8'd0);
    tick_until_idle(1'b1);
  endtask

  // Zero-length frame goes straight from header to trailer; the carrier
  // phase carries over from the frame before
  task automatic test_empty_frame();
    send_item(irpdt_pkg::OP_START, 1'b1, 8'd0);
    tick_until_idle(1'b0);
    send_item(irpdt_pkg::OP_START, 1'b0, 8'd4);
    tick_until_idle(1'b0);
  endtask

  // A timing of zero behaves like one
  task automatic test_zero_timing();
    set_timing(17'd1, 17'd0, 17'd2, 17'd0);
    send_item(irpdt_pkg::OP_WRITE, 1'b0, 8'd0);
    send_item(irpdt_pkg::OP_WRITE, 1'b1, 8'd0);
    send_item(irpdt_pkg::OP_START, 1'b0, 8'd2);
    tick_until_idle(1'b0);
  endtask

  // Hold the receiver off while the sender keeps offering, so the result
  // queue fills and stalls the input; then pause the sender until drained
  task automatic test_backpressure();
    set_timing(17'd2, 17'd2, 17'd3, 17'd3);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    stall_cycles_req = HOLD_CYCLES;
    repeat (6)
      send_item(irpdt_pkg::OP_WRITE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    send_item(irpdt_pkg::OP_START, 1'b0, 8'd6);
    tick_until_idle(1'b0);
    wait_drain();
  endtask

  // Well-formed frames with random content and timings, mixed with noise,
  // broken sequences, idle ticks and sender pauses
  task automatic test_random_traffic(input int unsigned quota, input bit idles);
    int unsigned target;
    int unsigned nbits;
    logic [7:0]  flen;
    target = items_done + quota;
    set_timing(17'($urandom_range(1, 6)), 17'($urandom_range(1, 5)),
               17'($urandom_range(1, 10)),
               17'(($urandom_range(0, 3) == 0) ? $urandom_range(8, 60)
                                               : $urandom_range(1, 6)));
    tx_idle_en = idles;
    rx_idle_en = idles;
    while (items_done < target) begin
      nbits = ($urandom_range(0, 15) == 0) ? $urandom_range(0, MAX_BITS + 2)
                                           : $urandom_range(0, 10);
      repeat (nbits)
        send_item(irpdt_pkg::OP_WRITE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      case ($urandom_range(0, 11))
        0: flen = 8'($urandom_range(0, 255));
        1, 2: flen = 8'($urandom_range(0, nbits));
        default: flen = (nbits > MAX_BITS) ? MAX_LEN : 8'(nbits);
      endcase
      if ($urandom_range(0, 7) == 0)
        send_item(($urandom_range(0, 1) != 0) ? OP_NONE : irpdt_pkg::OP_TICK,
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      send_item(irpdt_pkg::OP_START, 1'($urandom_range(0, 1)), flen);
      tick_until_idle(1'b1);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 5))
          send_item(irpdt_pkg::OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0) wait_drain();
    end
  endtask

  // Carrier half period at TIME_MAX, so it never fires in a short
  // frame; one '1' bit so short marks and a long space both run
  task automatic test_extreme_timing();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_timing(17'd1, 17'd1, 17'd20, TIME_MAX);
    send_item(irpdt_pkg::OP_WRITE, 1'b1, 8'd0);
    send_item(irpdt_pkg::OP_START, 1'b0, 8'd1);
    tick_until_idle(1'b0);
  endtask

  initial begin
    // known values on every input from time zero
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = irpdt_pkg::OP_TICK;
    in_ch.bit_value = 1'b0;
    in_ch.frame_length = 8'd0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    clear_transmitter_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_after_reset();
    test_full_buffer_frame();
    test_mixed_bit_frame();
    test_empty_frame();
    test_zero_timing();
    test_backpressure();
    test_random_traffic(20, 1'b1);
    test_random_traffic(20, 1'b1);
    // last stretch runs without idling on either side
    test_random_traffic(20, 1'b0);
    test_extreme_timing();

    wait_drain();
    // let a stray extra result surface before the verdict
    repeat (8) @(negedge clk);
    $display("Sent %0d frames, %0d timer ticks and %0d stored bits; checked %0d results.",
             frames_sent, ticks_sent, bits_written, results_seen);
    $display("Timing settings: %0d, from zero and one up to 65536, plus a %0d-cycle result stall.",
             settings_used, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== ir_pulse_distance_transmitter.f =====
rtl/core/irpdt_pkg.sv
rtl/core/irpdt_if.sv
rtl/core/ir_pulse_distance_transmitter.sv
verif/tb_ir_pulse_distance_transmitter.sv
